[rtl/sod_pkg.sv]
// shared constants, types and the opcode table of the scrambled opcode dispatch decoder
`default_nettype none

package sod_pkg;

    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NUM_SLOTS   = 32;
    localparam int unsigned NUM_CLASSES = 13;

    localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;

    localparam logic [CLASS_W-1:0] CLASS_ILLEGAL = 4'd0;
    localparam logic [SLOT_W-1:0]  SLOT_LAST     = 5'd31;
    localparam logic [SLOT_W-1:0]  SHUFFLE_LAST  = 5'd1;
    localparam logic [SLOT_W-1:0]  MAP_LAST      = 5'(NUM_CLASSES - 1);

    // remainder unit: one dividend bit per cycle over the upper lcg bits
    localparam int unsigned DIV_W = 15;
    localparam logic [3:0]  DIV_STEPS = 4'(DIV_W);
    localparam logic [3:0]  DIV_STEP_LAST = 4'd1;

    // command bundle from the controller to the datapath
    typedef struct packed {
        logic take;      // request accepted this cycle
        logic cnt_clr;
        logic cnt_inc;
        logic init_wr;   // identity / illegal sweep write
        logic lcg_load;  // lcg from seed, shuffle index to top
        logic lcg_mul;
        logic lcg_add;   // also starts the remainder unit
        logic mod_step;
        logic rd_i;
        logic rd_j;
        logic wr_i;
        logic wr_j;
        logic map_rd;
        logic map_wr;
        logic result;    // load output register and halt flag
    } sod_cmd_t;

    // status bundle from the datapath to the controller
    typedef struct packed {
        logic sweep_last;
        logic mod_last;
        logic shuffle_last;
        logic map_last;
        logic out_free;
    } sod_sts_t;

    // real opcode of each handler class, indexed by class minus one
    function automatic logic [SLOT_W-1:0] opcode_of_class(input logic [CLASS_W-1:0] k);
        logic [SLOT_W-1:0] op;
        unique case (k)
            4'd0:    op = 5'h00;
            4'd1:    op = 5'h03;
            4'd2:    op = 5'h04;
            4'd3:    op = 5'h05;
            4'd4:    op = 5'h06;
            4'd5:    op = 5'h08;
            4'd6:    op = 5'h0C;
            4'd7:    op = 5'h0D;
            4'd8:    op = 5'h0E;
            4'd9:    op = 5'h18;
            4'd10:   op = 5'h19;
            4'd11:   op = 5'h1B;
            4'd12:   op = 5'h1C;
            default: op = 5'h00;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

[rtl/sod_datapath.sv]
// datapath: seed and lcg, remainder unit, permutation and slot class memories, output register
`default_nettype none

module sod_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sod_pkg::WORD_W-1:0]    cfg_wdata,
    input  wire logic [sod_pkg::WORD_W-1:0]    instr_word,
    input  wire logic                          out_ready,
    input  wire sod_pkg::sod_cmd_t             cmd,
    output sod_pkg::sod_sts_t                  sts,
    output logic                               out_valid,
    output logic [sod_pkg::SLOT_W-1:0]         slot,
    output logic [sod_pkg::CLASS_W-1:0]        handler_class,
    output logic                               halted
);
    import sod_pkg::*;

    logic [WORD_W-1:0]  seed_reg;
    logic [WORD_W-1:0]  lcg_reg;
    logic [WORD_W-1:0]  prod_reg;
    logic [WORD_W-1:0]  lcg_sum;
    logic [SLOT_W-1:0]  i_reg;
    logic [SLOT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [SLOT_W-1:0]  rem_reg;
    logic [3:0]         mod_cnt_reg;
    logic [SLOT_W:0]    mod_trial;
    logic [SLOT_W:0]    mod_divisor;
    logic [SLOT_W-1:0]  rem_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  pi_reg;
    logic               halt_reg;
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [CLASS_W-1:0] out_class_reg;
    logic               out_halted_reg;

    logic [SLOT_W-1:0]  perm_mem [NUM_SLOTS];
    logic [CLASS_W-1:0] class_mem [NUM_SLOTS];
    logic [SLOT_W-1:0]  perm_raddr;
    logic [SLOT_W-1:0]  perm_rd_reg;
    logic               perm_we;
    logic [SLOT_W-1:0]  perm_waddr;
    logic [SLOT_W-1:0]  perm_wdata;
    logic               class_we;
    logic [SLOT_W-1:0]  class_waddr;
    logic [CLASS_W-1:0] class_wdata;
    logic [SLOT_W-1:0]  class_raddr;
    logic [CLASS_W-1:0] class_rd_reg;
    logic               class_is_illegal;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_we)
            seed_reg <= cfg_wdata;
    end

    // lcg: multiply then add, one register between
    assign lcg_sum = prod_reg + LCG_ADD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lcg_reg <= '0;
        else if (cmd.lcg_load)
            lcg_reg <= seed_reg;
        else if (cmd.lcg_add)
            lcg_reg <= lcg_sum;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lcg_mul)
            prod_reg <= WORD_W'(lcg_reg * LCG_MUL);
    end

    // shuffle index and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.lcg_load)
                i_reg <= SLOT_LAST;
            else if (cmd.wr_j)
                i_reg <= i_reg - 1'b1;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // restoring remainder by i+1, one dividend bit per step
    assign mod_trial   = {rem_reg, div_reg[DIV_W-1]};
    assign mod_divisor = {1'b0, i_reg} + 1'b1;
    assign rem_next    = (mod_trial >= mod_divisor) ? SLOT_W'(mod_trial - mod_divisor)
                                                    : mod_trial[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_cnt_reg <= '0;
        else if (cmd.lcg_add)
            mod_cnt_reg <= DIV_STEPS;
        else if (cmd.mod_step)
            mod_cnt_reg <= mod_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lcg_add)
        begin
            div_reg <= lcg_sum[WORD_W-1 -: DIV_W];
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            div_reg <= {div_reg[DIV_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // permutation memory ports
    always_comb
    begin
        perm_raddr = cnt_reg;
        if (cmd.rd_i)
            perm_raddr = i_reg;
        else if (cmd.rd_j)
            perm_raddr = rem_reg;
        else if (cmd.map_rd)
            perm_raddr = opcode_of_class(cnt_reg[CLASS_W-1:0]);

        perm_we    = cmd.init_wr | cmd.wr_i | cmd.wr_j;
        perm_waddr = cnt_reg;
        perm_wdata = cnt_reg;
        if (cmd.wr_i)
        begin
            perm_waddr = i_reg;
            perm_wdata = perm_rd_reg;
        end
        else if (cmd.wr_j)
        begin
            perm_waddr = rem_reg;
            perm_wdata = pi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_waddr] <= perm_wdata;
        perm_rd_reg <= perm_mem[perm_raddr];
        if (cmd.rd_j)
            pi_reg <= perm_rd_reg;
    end

    // slot class memory ports
    always_comb
    begin
        class_we    = cmd.init_wr | cmd.map_wr;
        class_waddr = cmd.map_wr ? perm_rd_reg : cnt_reg;
        class_wdata = cmd.map_wr ? CLASS_W'(cnt_reg) + 1'b1 : CLASS_ILLEGAL;
        class_raddr = cmd.take ? instr_word[6:2] : slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (class_we)
            class_mem[class_waddr] <= class_wdata;
        class_rd_reg <= class_mem[class_raddr];
        if (cmd.take)
            slot_reg <= instr_word[6:2];
    end

    // sticky halt and output register
    assign class_is_illegal = (class_rd_reg == CLASS_ILLEGAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.result)
            begin
                halt_reg      <= halt_reg | class_is_illegal;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            out_slot_reg   <= slot_reg;
            out_class_reg  <= halt_reg ? CLASS_ILLEGAL : class_rd_reg;
            out_halted_reg <= halt_reg | class_is_illegal;
        end
    end

    // status to the controller
    always_comb
    begin
        sts.sweep_last   = (cnt_reg == SLOT_LAST);
        sts.map_last     = (cnt_reg == MAP_LAST);
        sts.shuffle_last = (i_reg == SHUFFLE_LAST);
        sts.mod_last     = (mod_cnt_reg == DIV_STEP_LAST);
        sts.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign slot          = out_slot_reg;
    assign handler_class = out_class_reg;
    assign halted        = out_halted_reg;

endmodule

`default_nettype wire

[rtl/sod_ctrl.sv]
// controller: sequences the table build, the lookup and the result hand-off
`default_nettype none

module sod_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sod_pkg::sod_sts_t sts,
    output sod_pkg::sod_cmd_t      cmd
);
    import sod_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_INIT    = 13'b0000000000010,
        ST_LCG_MUL = 13'b0000000000100,
        ST_LCG_ADD = 13'b0000000001000,
        ST_MOD     = 13'b0000000010000,
        ST_RD_I    = 13'b0000000100000,
        ST_RD_J    = 13'b0000001000000,
        ST_WR_I    = 13'b0000010000000,
        ST_WR_J    = 13'b0000100000000,
        ST_MAP_RD  = 13'b0001000000000,
        ST_MAP_WR  = 13'b0010000000000,
        ST_LOOK    = 13'b0100000000000,
        ST_RESULT  = 13'b1000000000000
    } sod_state_t;

    sod_state_t state_reg;
    sod_state_t state_next;
    logic       built_reg;
    logic       built_next;

    // state and build flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            built_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        built_next = built_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (built_reg)
                        state_next = ST_RESULT;
                    else
                    begin
                        cmd.cnt_clr  = 1'b1;
                        cmd.lcg_load = 1'b1;
                        state_next   = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.sweep_last)
                    state_next = ST_LCG_MUL;
            end
            ST_LCG_MUL:
            begin
                cmd.lcg_mul = 1'b1;
                state_next  = ST_LCG_ADD;
            end
            ST_LCG_ADD:
            begin
                cmd.lcg_add = 1'b1;
                state_next  = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                    state_next = ST_RD_I;
            end
            ST_RD_I:
            begin
                cmd.rd_i   = 1'b1;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                cmd.rd_j   = 1'b1;
                state_next = ST_WR_I;
            end
            ST_WR_I:
            begin
                cmd.wr_i   = 1'b1;
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                cmd.wr_j = 1'b1;
                if (sts.shuffle_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_MAP_RD;
                end
                else
                    state_next = ST_LCG_MUL;
            end
            ST_MAP_RD:
            begin
                cmd.map_rd = 1'b1;
                state_next = ST_MAP_WR;
            end
            ST_MAP_WR:
            begin
                cmd.map_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.map_last)
                begin
                    built_next = 1'b1;
                    state_next = ST_LOOK;
                end
                else
                    state_next = ST_MAP_RD;
            end
            ST_LOOK:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/scrambled_opcode_dispatch_decoder.sv]
// top level of the scrambled opcode dispatch decoder
`default_nettype none

// Maps each instruction word to a handler class through a slot table that is
// scrambled by a seeded shuffle. The first request after reset triggers the table
// build, using the seed held at that moment: a sweep over all 32 slots that loads
// the identity permutation and marks every slot illegal, 31 shuffle rounds (lcg
// multiply, lcg add, bit-serial remainder over 15 dividend bits, two reads and two
// writes on the permutation memory), and a pass that writes the 13 classes into the
// slot table, then a lookup state that reads the slot table before the result is
// registered. Every later request is accepted in a cycle that also reads the slot
// table; the output register is loaded in the result state, once the output is
// free. A new request is taken while the previous result still waits in the
// output register. Meeting an illegal slot sets a sticky halt: from then on every
// request returns class illegal with halted set. A seed written after the first
// request has no effect on the table, and reset clears the seed register to zero.
module scrambled_opcode_dispatch_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sod_pkg::WORD_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sod_pkg::WORD_W-1:0]    instr_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sod_pkg::SLOT_W-1:0]         slot,
    output logic [sod_pkg::CLASS_W-1:0]        handler_class,
    output logic                               halted
);
    import sod_pkg::*;

    sod_cmd_t cmd;
    sod_sts_t sts;

    // sequencing
    sod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, arithmetic and output register
    sod_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .instr_word    (instr_word),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .slot          (slot),
        .handler_class (handler_class),
        .halted        (halted)
    );

endmodule

`default_nettype wire
